// ----- rtl/core/fce_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath interface types of the cluster table engine
package fce_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);

    localparam int ACT_W   = 3;
    localparam int ENTRY_W = 16;
    localparam int CNT_W   = 13;
    localparam int ST_W    = 2;

    localparam int IN_FIELDS_W  = ACT_W + 2 * ENTRY_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ENTRY_W + ST_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [ENTRY_W-1:0] LINK_EOC   = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] LINK_FREE  = 16'h0000;
    localparam logic [ENTRY_W-1:0] FIRST_DATA = 16'd2;

    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_EXTEND = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FREE   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [ST_W-1:0] ST_BROKEN = 2'd3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_READ,
        OP_RD_DATA,
        OP_WRITE,
        OP_SEEK_INIT,
        OP_SEEK,
        OP_LINK,
        OP_EOC,
        OP_FREE_RD,
        OP_FREE_DATA,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op             op;
        logic            in_ready;
        logic            set_st;
        logic [ST_W-1:0] st;
    } t_cmd;

    typedef struct packed {
        logic             in_fire;
        logic [ACT_W-1:0] action;
        logic             cl_ok;
        logic             cl_data_ok;
        logic             cl_eoc;
        logic             seek_hit;
        logic             seek_end;
        logic             nxt_eoc;
        logic             nxt_bad;
        logic             steps_end;
        logic             clr_last;
        logic             out_free;
    } t_sts;

endpackage

// ----- rtl/core/fce_ram.sv -----
`timescale 1ns / 1ps
// generic single-port ram with registered read data
module fce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/fce_datapath.sv -----
`timescale 1ns / 1ps
// datapath of the cluster table engine: item registers, table memory, search and walk registers
module fce_datapath import fce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [CNT_W-1:0]       i_count,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [ACT_W-1:0]       r_act;
    logic [ENTRY_W-1:0]     r_cl;
    logic [ENTRY_W-1:0]     r_val;
    logic [ENTRY_W-1:0]     r_cur;
    logic [TABLE_AW-1:0]    r_clr;
    logic [CNT_W-1:0]       r_ptr;
    logic                   r_pend;
    logic [TABLE_AW-1:0]    r_f;
    logic [CNT_W-1:0]       r_steps;
    logic [ENTRY_W-1:0]     r_res;
    logic [ST_W-1:0]        r_st;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                ram_we;
    logic [TABLE_AW-1:0] ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic               fire;
    logic [ENTRY_W-1:0] count_ext;
    logic [CNT_W:0]     steps_inc;

    fce_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign fire      = i_cmd.in_ready & s_axis_tvalid;
    assign count_ext = ENTRY_W'(i_count);
    assign steps_inc = (CNT_W + 1)'(r_steps) + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_cl[TABLE_AW-1:0];
        ram_wdata = r_val;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = LINK_FREE;
            end
            OP_WRITE: begin
                ram_we = 1'b1;
            end
            OP_SEEK: begin
                ram_addr = r_ptr[TABLE_AW-1:0];
            end
            OP_LINK: begin
                ram_we    = 1'b1;
                ram_wdata = ENTRY_W'(r_f);
            end
            OP_EOC: begin
                ram_we    = 1'b1;
                ram_addr  = r_f;
                ram_wdata = LINK_EOC;
            end
            OP_FREE_RD: begin
                ram_addr = r_cur[TABLE_AW-1:0];
            end
            OP_FREE_DATA: begin
                ram_we    = 1'b1;
                ram_addr  = r_cur[TABLE_AW-1:0];
                ram_wdata = LINK_FREE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.in_fire    = fire;
        o_sts.action     = r_act;
        o_sts.cl_ok      = r_cl < count_ext;
        o_sts.cl_data_ok = (r_cl < count_ext) && (r_cl >= FIRST_DATA);
        o_sts.cl_eoc     = r_cl == LINK_EOC;
        o_sts.seek_hit   = r_pend && (ram_rdata == LINK_FREE);
        o_sts.seek_end   = r_ptr >= i_count;
        o_sts.nxt_eoc    = ram_rdata == LINK_EOC;
        o_sts.nxt_bad    = (ram_rdata != LINK_EOC)
                           && ((ram_rdata < FIRST_DATA) || (ram_rdata >= count_ext));
        o_sts.steps_end  = steps_inc >= (CNT_W + 1)'(i_count);
        o_sts.clr_last   = r_clr == TABLE_AW'(TABLE_ENTRIES - 1);
        o_sts.out_free   = !r_out_valid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_act   <= s_axis_tdata[ACT_W-1:0];
            r_cl    <= s_axis_tdata[ACT_W +: ENTRY_W];
            r_val   <= s_axis_tdata[ACT_W + ENTRY_W +: ENTRY_W];
            r_cur   <= s_axis_tdata[ACT_W +: ENTRY_W];
            r_steps <= '0;
            r_res   <= '0;
            r_st    <= ST_OK;
        end else begin
            unique case (i_cmd.op)
                OP_SEEK_INIT: begin
                    r_ptr  <= CNT_W'(FIRST_DATA);
                    r_pend <= 1'b0;
                end
                OP_SEEK: begin
                    r_f <= r_ptr[TABLE_AW-1:0] - 1'b1;
                    if (r_ptr < i_count) begin
                        r_ptr  <= r_ptr + 1'b1;
                        r_pend <= 1'b1;
                    end
                end
                OP_RD_DATA: begin
                    r_res <= ram_rdata;
                end
                OP_EOC: begin
                    r_res <= ENTRY_W'(r_f);
                end
                OP_FREE_DATA: begin
                    r_cur   <= ram_rdata;
                    r_steps <= steps_inc[CNT_W-1:0];
                end
                OP_OUT: begin
                    r_out_data <= OUT_TDATA_W'({r_steps, r_st, r_res});
                end
                default: begin
                end
            endcase
            if (i_cmd.set_st) begin
                r_st <= i_cmd.st;
            end
        end
    end

    assign s_axis_tready = i_cmd.in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/core/fce_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine of the cluster table engine
module fce_ctrl import fce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RD_DATA,
        S_SEEK,
        S_LINK,
        S_EOC,
        S_FREE_RD,
        S_FREE_DATA,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.op        = OP_NOP;
        o_cmd.in_ready  = 1'b0;
        o_cmd.set_st    = 1'b0;
        o_cmd.st        = ST_OK;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.action)
                    ACT_READ: begin
                        if (i_sts.cl_ok) begin
                            o_cmd.op = OP_READ;
                            n_state  = S_RD_DATA;
                        end else begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_RANGE;
                            n_state      = S_RESP;
                        end
                    end
                    ACT_WRITE: begin
                        if (i_sts.cl_ok) begin
                            o_cmd.op = OP_WRITE;
                        end else begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_RANGE;
                        end
                        n_state = S_RESP;
                    end
                    ACT_ALLOC: begin
                        o_cmd.op = OP_SEEK_INIT;
                        n_state  = S_SEEK;
                    end
                    ACT_EXTEND: begin
                        if (i_sts.cl_data_ok) begin
                            o_cmd.op = OP_SEEK_INIT;
                            n_state  = S_SEEK;
                        end else begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_RANGE;
                            n_state      = S_RESP;
                        end
                    end
                    ACT_FREE: begin
                        if (i_sts.cl_eoc) begin
                            n_state = S_RESP;
                        end else if (i_sts.cl_data_ok) begin
                            n_state = S_FREE_RD;
                        end else begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_RANGE;
                            n_state      = S_RESP;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_RD_DATA: begin
                o_cmd.op = OP_RD_DATA;
                n_state  = S_RESP;
            end
            S_SEEK: begin
                o_cmd.op = OP_SEEK;
                if (i_sts.seek_hit) begin
                    n_state = (i_sts.action == ACT_EXTEND) ? S_LINK : S_EOC;
                end else if (i_sts.seek_end) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_FULL;
                    n_state      = S_RESP;
                end
            end
            S_LINK: begin
                o_cmd.op = OP_LINK;
                n_state  = S_EOC;
            end
            S_EOC: begin
                o_cmd.op = OP_EOC;
                n_state  = S_RESP;
            end
            S_FREE_RD: begin
                o_cmd.op = OP_FREE_RD;
                n_state  = S_FREE_DATA;
            end
            S_FREE_DATA: begin
                o_cmd.op = OP_FREE_DATA;
                if (i_sts.nxt_eoc) begin
                    n_state = S_RESP;
                end else if (i_sts.nxt_bad || i_sts.steps_end) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_BROKEN;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_FREE_RD;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/fat16_cluster_table_engine.sv -----
`timescale 1ns / 1ps
// fat16 cluster table engine: top level with the configuration register
//
// usage
//   s_axis carries one command per transfer: action, cluster and entry value.
//   m_axis returns one result per command: result cluster, status, freed count.
//   apb register 0 (cluster_count) limits the table; write it only while idle.
// reset
//   after reset the table is swept to all free, one entry per cycle;
//   s_axis_tready stays low until the sweep is done.
// operation
//   one command is handled at a time; every table access goes through the
//   single port of the table ram. allocate and extend scan upward from
//   entry 2 for the first free entry; free clears the chain entry by entry.
// stall
//   the result sits in an output register; while m_axis_tready is low the
//   engine finishes the next command and then waits before its result.
module fat16_cluster_table_engine import fce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // action, cluster, entry_value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // result_cluster, status, freed_count
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam logic [APB_AW-3:0] REG_CLUSTER_COUNT = '0;
    localparam logic [CNT_W-1:0]  COUNT_RESET       = 13'd4096;
    localparam logic [CNT_W-1:0]  COUNT_MAX         = CNT_W'(TABLE_ENTRIES);

    logic [CNT_W-1:0] r_cluster_count;
    logic [CNT_W-1:0] live_count;
    logic             reg_hit;
    t_cmd             cmd;
    t_sts             sts;

    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_AW-1:2] == REG_CLUSTER_COUNT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= COUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_cluster_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata     = reg_hit ? APB_DW'(r_cluster_count) : '0;
    assign live_count = (r_cluster_count > COUNT_MAX) ? COUNT_MAX : r_cluster_count;

    fce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fce_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_count       (live_count),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- rtl/core/fce_checker.sv -----
`timescale 1ns / 1ps
// port-level checker of the cluster table engine and its bind
module fce_checker import fce_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [ENTRY_W-1:0] res_f;
    logic [ST_W-1:0]    st_f;
    logic [CNT_W-1:0]   freed_f;

    assign res_f   = m_axis_tdata[ENTRY_W-1:0];
    assign st_f    = m_axis_tdata[ENTRY_W +: ST_W];
    assign freed_f = m_axis_tdata[ENTRY_W + ST_W +: CNT_W];

    // table sweep blocks commands and no result is pending after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!s_axis_tready && !m_axis_tvalid))
        else $error("engine not quiet after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (st_f == ST_FULL || st_f == ST_RANGE)) |->
            (res_f == LINK_FREE && freed_f == '0))
        else $error("failed command carries a result");

    a_freed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && freed_f != '0) |-> (st_f == ST_OK || st_f == ST_BROKEN))
        else $error("freed count with a wrong status");

endmodule

bind fat16_cluster_table_engine fce_checker u_fce_checker (.*);

// ----- tb/tb_fat16_cluster_table_engine.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the fat16 cluster table engine: table-driven directed part, then random phases
module tb_fat16_cluster_table_engine;
    import fce_pkg::*;

    localparam logic [ACT_W-1:0]  ACT_RSVD5         = 3'd5;
    localparam logic [ACT_W-1:0]  ACT_RSVD7         = 3'd7;
    localparam logic [APB_AW-1:0] REG_CLUSTER_COUNT = 3'd0;
    localparam logic [CNT_W-1:0]  FREED_MAX         = 13'h1FFF;
    localparam int                PHASE_ITEMS       = 92;

    typedef struct packed {
        logic [ENTRY_W-1:0] link;
        logic [ST_W-1:0]    st;
        logic [CNT_W-1:0]   freed;
    } t_result;

    typedef struct packed {
        logic               is_cfg;
        logic [CNT_W-1:0]   cfg;
        logic [ACT_W-1:0]   act;
        logic [ENTRY_W-1:0] cl;
        logic [ENTRY_W-1:0] val;
        logic               chk;
        t_result            want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // action, cluster, entry_value
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // result_cluster, status, freed_count
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    logic [ENTRY_W-1:0] fat_mirror [TABLE_ENTRIES];
    logic [CNT_W-1:0]   count_cfg = 13'd4096;
    t_result            pending_results [$];
    t_result            last_result;
    t_dir_row           directed_rows [$];
    int unsigned        chain_head [$];
    int unsigned        chain_tail [$];
    int unsigned        hi_mark = 2;
    int                 burst_left = 0;
    int                 err_cnt = 0;
    int                 rx_left = 0;
    int                 rx_mode = 0;

    fat16_cluster_table_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned live_count();
        return (count_cfg > TABLE_ENTRIES) ? TABLE_ENTRIES : 32'(count_cfg);
    endfunction

    function automatic int unsigned first_free(input int unsigned n);
        for (int unsigned i = 32'(FIRST_DATA); i < n; i++) begin
            if (fat_mirror[i] == LINK_FREE) return i;
        end
        return 0;
    endfunction

    // applies one command to the mirror table and returns its result
    function automatic t_result fat_apply(input logic [ACT_W-1:0] act,
                                          input logic [ENTRY_W-1:0] cl,
                                          input logic [ENTRY_W-1:0] val);
        t_result     r;
        int unsigned n;
        int unsigned f;
        int unsigned cur;
        int unsigned nxt;
        int unsigned steps;
        r = '0;
        n = live_count();
        case (act)
            ACT_READ: begin
                if (cl < n) r.link = fat_mirror[cl];
                else r.st = ST_RANGE;
            end
            ACT_WRITE: begin
                if (cl < n) fat_mirror[cl] = val;
                else r.st = ST_RANGE;
            end
            ACT_ALLOC: begin
                f = first_free(n);
                if (f == 0) begin
                    r.st = ST_FULL;
                end else begin
                    fat_mirror[f] = LINK_EOC;
                    r.link = ENTRY_W'(f);
                end
            end
            ACT_EXTEND: begin
                if (cl < FIRST_DATA || cl >= n) begin
                    r.st = ST_RANGE;
                end else begin
                    f = first_free(n);
                    if (f == 0) begin
                        r.st = ST_FULL;
                    end else begin
                        fat_mirror[cl] = ENTRY_W'(f);
                        fat_mirror[f] = LINK_EOC;
                        r.link = ENTRY_W'(f);
                    end
                end
            end
            ACT_FREE: begin
                if (cl == LINK_EOC) begin
                    r = '0;
                end else if (cl < FIRST_DATA || cl >= n) begin
                    r.st = ST_RANGE;
                end else begin
                    cur = 32'(cl);
                    steps = 0;
                    while (cur != LINK_EOC) begin
                        if (steps >= n) begin
                            r.st = ST_BROKEN;
                            break;
                        end
                        steps++;
                        nxt = 32'(fat_mirror[cur]);
                        fat_mirror[cur] = LINK_FREE;
                        if (r.freed != FREED_MAX) r.freed++;
                        if (nxt != LINK_EOC && (nxt < FIRST_DATA || nxt >= n)) begin
                            r.st = ST_BROKEN;
                            break;
                        end
                        cur = nxt;
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_dir_row chk_row(input logic [ACT_W-1:0] act,
                                         input logic [ENTRY_W-1:0] cl,
                                         input logic [ENTRY_W-1:0] val,
                                         input logic [ENTRY_W-1:0] link,
                                         input logic [ST_W-1:0] st,
                                         input logic [CNT_W-1:0] freed);
        return '{1'b0, '0, act, cl, val, 1'b1, '{link, st, freed}};
    endfunction

    function automatic t_dir_row pred_row(input logic [ACT_W-1:0] act,
                                          input logic [ENTRY_W-1:0] cl,
                                          input logic [ENTRY_W-1:0] val);
        return '{1'b0, '0, act, cl, val, 1'b0, '0};
    endfunction

    function automatic t_dir_row cfg_row(input logic [CNT_W-1:0] cnt);
        return '{1'b1, cnt, ACT_READ, '0, '0, 1'b0, '0};
    endfunction

    // cluster mostly inside the part of the table in use, sometimes at the range edges or anywhere
    function automatic logic [ENTRY_W-1:0] near_cluster();
        int unsigned n;
        int unsigned span;
        int unsigned k;
        n = live_count();
        span = (hi_mark + 4 < n) ? hi_mark + 4 : n;
        k = $urandom_range(0, 19);
        if (k < 17) return ENTRY_W'($urandom_range(0, span - 1));
        if (k == 17) return ENTRY_W'(n - 1);
        if (k == 18) return ENTRY_W'(n);
        return ENTRY_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [ENTRY_W-1:0] cl,
                            input logic [ENTRY_W-1:0] val, input logic chk,
                            input t_result want);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, val, cl, act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        last_result = fat_apply(act, cl, val);
        pending_results.push_back(chk ? want : last_result);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cluster_count(input logic [APB_DW-1:0] wdata);
        logic [CNT_W-1:0] cnt;
        cnt = wdata[CNT_W-1:0];
        drain_results();
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = REG_CLUSTER_COUNT;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        count_cfg = cnt;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(APB_DW - CNT_W){1'b0}}, cnt}) begin
            $error("cluster_count readback: expected %0d, got %0d", cnt, prdata);
            err_cnt++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // receiver: ready stretches, random stalls and long stalls
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 60);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = 1'($urandom_range(0, 1));
            default: m_axis_tready = ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.link = m_axis_tdata[ENTRY_W-1:0];
            seen.st = m_axis_tdata[ENTRY_W +: ST_W];
            seen.freed = m_axis_tdata[ENTRY_W+ST_W +: CNT_W];
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (seen.link !== want.link) begin
                    $error("result_cluster: expected %h, got %h", want.link, seen.link);
                    err_cnt++;
                end
                if (seen.st !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, seen.st);
                    err_cnt++;
                end
                if (seen.freed !== want.freed) begin
                    $error("freed_count: expected %0d, got %0d", want.freed, seen.freed);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("** fat16_cluster_table_engine: FAILED **");
        $finish;
    end

    initial begin
        int unsigned        phase_counts [6];
        logic [APB_DW-1:0]  wdata;
        logic [ACT_W-1:0]   act;
        logic [ENTRY_W-1:0] cl;
        logic [ENTRY_W-1:0] val;
        int unsigned        k;
        int                 idx;

        foreach (fat_mirror[i]) fat_mirror[i] = LINK_FREE;

        directed_rows.push_back(chk_row(ACT_READ, 16'd0, 16'd0, 16'd0, ST_OK, 13'd0));
        directed_rows.push_back(chk_row(ACT_READ, 16'd4095, 16'hFFFF, 16'd0, ST_OK, 13'd0));
        directed_rows.push_back(chk_row(ACT_READ, 16'd4096, 16'd0, 16'd0, ST_RANGE, 13'd0));
        directed_rows.push_back(chk_row(ACT_WRITE, 16'hFFFF, 16'hFFFF, 16'd0, ST_RANGE, 13'd0));
        directed_rows.push_back(chk_row(ACT_ALLOC, 16'd0, 16'd0, 16'd2, ST_OK, 13'd0));
        directed_rows.push_back(chk_row(ACT_ALLOC, 16'hFFFF, 16'hFFFF, 16'd3, ST_OK, 13'd0));
        directed_rows.push_back(chk_row(ACT_EXTEND, 16'd3, 16'd0, 16'd4, ST_OK, 13'd0));
        directed_rows.push_back(pred_row(ACT_READ, 16'd3, 16'd0));
        directed_rows.push_back(chk_row(ACT_EXTEND, 16'd1, 16'd0, 16'd0, ST_RANGE, 13'd0));
        directed_rows.push_back(chk_row(ACT_EXTEND, 16'd4096, 16'd0, 16'd0, ST_RANGE, 13'd0));
        directed_rows.push_back(chk_row(ACT_FREE, LINK_EOC, 16'd0, 16'd0, ST_OK, 13'd0));
        directed_rows.push_back(chk_row(ACT_FREE, 16'd0, 16'd0, 16'd0, ST_RANGE, 13'd0));
        directed_rows.push_back(pred_row(ACT_FREE, 16'd3, 16'd0));
        // extend a free cluster: it becomes its own one-entry chain
        directed_rows.push_back(pred_row(ACT_EXTEND, 16'd3, 16'd0));
        directed_rows.push_back(chk_row(ACT_WRITE, 16'd1, 16'h1234, 16'd0, ST_OK, 13'd0));
        directed_rows.push_back(pred_row(ACT_READ, 16'd1, 16'd0));
        // broken chains: reserved link, self loop, link past the count
        directed_rows.push_back(pred_row(ACT_WRITE, 16'd10, 16'd1));
        directed_rows.push_back(pred_row(ACT_FREE, 16'd10, 16'd0));
        directed_rows.push_back(pred_row(ACT_WRITE, 16'd11, 16'd11));
        directed_rows.push_back(pred_row(ACT_FREE, 16'd11, 16'd0));
        directed_rows.push_back(pred_row(ACT_WRITE, 16'd12, 16'h8000));
        directed_rows.push_back(pred_row(ACT_FREE, 16'd12, 16'd0));
        directed_rows.push_back(chk_row(ACT_RSVD5, 16'hFFFF, 16'hFFFF, 16'd0, ST_OK, 13'd0));
        directed_rows.push_back(chk_row(ACT_RSVD7, 16'd2, 16'd5, 16'd0, ST_OK, 13'd0));
        // smallest table: only cluster 2 is usable and already taken
        directed_rows.push_back(cfg_row(13'd3));
        directed_rows.push_back(chk_row(ACT_ALLOC, 16'd0, 16'd0, 16'd0, ST_FULL, 13'd0));
        directed_rows.push_back(chk_row(ACT_EXTEND, 16'd2, 16'd0, 16'd0, ST_FULL, 13'd0));
        directed_rows.push_back(chk_row(ACT_READ, 16'd3, 16'd0, 16'd0, ST_RANGE, 13'd0));
        directed_rows.push_back(pred_row(ACT_FREE, 16'd2, 16'd0));
        directed_rows.push_back(chk_row(ACT_ALLOC, 16'd0, 16'd0, 16'd2, ST_OK, 13'd0));

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_cluster_count({{(APB_DW - CNT_W){1'b0}}, directed_rows[i].cfg});
            else
                send_cmd(directed_rows[i].act, directed_rows[i].cl, directed_rows[i].val,
                         directed_rows[i].chk, directed_rows[i].want);
        end

        phase_counts = '{4096, 3, 17, 8191, 300, 0};
        phase_counts[5] = $urandom_range(3, 4096);
        for (int p = 0; p < 6; p++) begin
            wdata = phase_counts[p];
            if (p == 5) wdata = ($urandom & ~32'h1FFF) | phase_counts[p];
            write_cluster_count(wdata);
            chain_head.delete();
            chain_tail.delete();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == PHASE_ITEMS / 2) drain_results();
                k = $urandom_range(0, 99);
                act = ACT_READ;
                cl = near_cluster();
                val = ENTRY_W'($urandom_range(0, 16'hFFFF));
                idx = -1;
                if (k < 25 && chain_head.size() < 48) begin
                    act = ACT_ALLOC;
                end else if (k < 45) begin
                    act = ACT_EXTEND;
                    if (chain_tail.size() != 0) begin
                        idx = int'($urandom_range(0, chain_tail.size() - 1));
                        cl = ENTRY_W'(chain_tail[idx]);
                    end
                end else if (k < 62) begin
                    act = ACT_FREE;
                    if (chain_head.size() != 0) begin
                        idx = int'($urandom_range(0, chain_head.size() - 1));
                        cl = ENTRY_W'(chain_head[idx]);
                        chain_head.delete(idx);
                        chain_tail.delete(idx);
                        idx = -1;
                    end
                end else if (k < 75) begin
                    act = ACT_READ;
                end else if (k < 87) begin
                    act = ACT_WRITE;
                    case ($urandom_range(0, 3))
                        0: val = LINK_FREE;
                        1: val = LINK_EOC;
                        2: val = near_cluster();
                        default: val = ENTRY_W'($urandom_range(0, 16'hFFFF));
                    endcase
                end else begin
                    act = ACT_W'($urandom_range(0, 7));
                    cl = ENTRY_W'($urandom_range(0, 16'hFFFF));
                end
                send_cmd(act, cl, val, 1'b0, '0);
                if (last_result.st == ST_OK && (act == ACT_ALLOC || act == ACT_EXTEND)) begin
                    if (act == ACT_ALLOC) begin
                        chain_head.push_back(32'(last_result.link));
                        chain_tail.push_back(32'(last_result.link));
                    end else if (idx >= 0) begin
                        chain_tail[idx] = 32'(last_result.link);
                    end
                    if (last_result.link > hi_mark) hi_mark = 32'(last_result.link);
                end
            end
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0)
            $display("** fat16_cluster_table_engine: PASSED **");
        else
            $display("** fat16_cluster_table_engine: FAILED **");
        $finish;
    end

endmodule
